[hdl/gptw_pkg.sv]
// ----------------------------------------------------------------------------
// Guest page table walker package
// Shared constants and transaction payload types for the walker and its
// channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package gptw_pkg;

  // Width of a guest physical address; table and frame addresses stay below it.
  localparam int PHYS_ADDR_BITS = 52;
  localparam logic [63:0] PHYS_MASK = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
  localparam logic [63:0] ADDR_MASK = PHYS_MASK & ~64'h0000_0000_0000_0FFF;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PAGING_MODE = 3'd0;
  localparam logic [2:0] CFG_ROOT_POINTER = 3'd1;
  localparam logic [2:0] CFG_WRITE_PROTECT = 3'd2;
  localparam logic [2:0] CFG_NO_EXEC = 3'd3;
  localparam logic [2:0] CFG_LARGE_PAGE = 3'd4;
  localparam logic [2:0] CFG_SMAP = 3'd5;
  localparam logic [2:0] CFG_SMEP = 3'd6;

  // Paging modes.
  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_TWO_LEVEL = 2'd1;
  localparam logic [1:0] MODE_PAE = 2'd2;
  localparam logic [1:0] MODE_FOUR_LEVEL = 2'd3;

  // Input transaction kinds.
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_REPLY = 1'b1;

  // Result transaction kinds.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Paging entry bit positions.
  localparam int BIT_P = 0;
  localparam int BIT_RW = 1;
  localparam int BIT_US = 2;
  localparam int BIT_PS = 7;
  localparam int BIT_NX = 63;

  typedef struct packed {
    logic        func;
    logic [63:0] virt_addr;
    logic        is_write;
    logic        is_fetch;
    logic        user_access;
    logic        align_check_flag;
    logic [63:0] table_entry;
    logic        entry_error;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [51:0] read_addr;
    logic        read_wide;
    logic [63:0] phys_addr;
    logic        status;
    logic [4:0]  fault_code;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/gptw_if.sv]
// ----------------------------------------------------------------------------
// Guest page table walker channel interfaces
// Valid/ready channels for walker requests and replies, and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gptw_in_if;
  logic              valid;
  logic              ready;
  gptw_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gptw_out_if;
  logic               valid;
  logic               ready;
  gptw_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/guest_page_table_walker_core.sv]
// ----------------------------------------------------------------------------
// Guest page table walker core
// Walks x86 guest page tables one level per reply and reports a table read,
// a translated address or a page fault with its error code.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_chan   sink       translation requests and table entry replies
//  out_chan  source     table read requests and finished translations
//  cfg_*     input      register writes (index, data), no read-back
//
//  One transaction per cycle while the skid is free: each is evaluated in the
//  same cycle against the walk state; any result lands in the output stage.
//  A two-entry output stage (output register plus skid) lets a transaction
//  be accepted while a result still waits; in_chan.ready drops only when
//  the skid entry is full. Synchronous active-low reset idles the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module guest_page_table_walker_core (
  input  wire                 clk,
  input  wire                 rst_n,
  gptw_in_if.sink             in_chan,
  gptw_out_if.source          out_chan,
  input  wire                 cfg_we,
  input  wire [2:0]           cfg_index,
  input  wire [51:0]          cfg_data
);

  // Base plus index of the virtual address at a level, scaled by entry size.
  function automatic logic [51:0] read_addr_f(input logic [51:0] base,
                                              input logic [63:0] va,
                                              input logic        w10,
                                              input logic [1:0]  lvl);
    logic [9:0]  idx;
    logic [51:0] off;
    case ({w10, lvl})
      3'b000:  idx = {1'b0, va[20:12]};
      3'b001:  idx = {1'b0, va[29:21]};
      3'b010:  idx = {1'b0, va[38:30]};
      3'b011:  idx = {1'b0, va[47:39]};
      3'b100:  idx = va[21:12];
      3'b101:  idx = va[31:22];
      3'b110:  idx = va[41:32];
      3'b111:  idx = va[51:42];
      default: idx = '0;
    endcase
    off = w10 ? {40'b0, idx, 2'b00} : {39'b0, idx, 3'b000};
    return base + off;
  endfunction

  // Page offset width for a walk that ends at the given level.
  function automatic logic [5:0] page_shift_f(input logic w10, input logic [1:0] lvl);
    logic [5:0] sh;
    case ({w10, lvl})
      3'b000:  sh = 6'd12;
      3'b001:  sh = 6'd21;
      3'b010:  sh = 6'd30;
      3'b011:  sh = 6'd39;
      3'b100:  sh = 6'd12;
      3'b101:  sh = 6'd22;
      3'b110:  sh = 6'd32;
      3'b111:  sh = 6'd42;
      default: sh = 6'd12;
    endcase
    return sh;
  endfunction

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [51:0] root_r;
  logic        wp_r;
  logic        nxe_r;
  logic        pse_r;
  logic        smap_r;
  logic        smep_r;

  // Walk state.
  logic        walk_busy_r, walk_busy_nxt;
  logic        pdpte_stage_r, pdpte_stage_nxt;
  logic [2:0]  levels_left_r, levels_left_nxt;
  logic [63:0] pending_addr_r, pending_addr_nxt;
  logic [3:0]  req_flags_r, req_flags_nxt;
  logic [51:0] table_base_r, table_base_nxt;
  logic        all_user_r, all_user_nxt;
  logic        all_writable_r, all_writable_nxt;

  // Output stage.
  logic                out_valid_r;
  gptw_pkg::out_item_t out_data_r;
  logic                skid_valid_r;
  gptw_pkg::out_item_t skid_data_r;

  logic                in_take;
  logic                out_take;
  logic                res_vld;
  gptw_pkg::out_item_t res;

  gptw_pkg::in_item_t  item;
  logic                two;
  logic                w10;
  logic                pse;
  logic                nxe;
  logic [63:0]         entry;
  logic                f_wr, f_fe, f_us, f_ac;
  logic                prot;
  logic                fault;
  logic                finish;
  logic                au_new, aw_new;
  logic [1:0]          lvl_i;
  logic [63:0]         off_mask;
  logic [51:0]         new_base;
  logic [32:0]         pdpte_addr;

  assign item     = in_chan.data;
  assign in_chan.ready = !skid_valid_r;
  assign in_take  = in_chan.valid && !skid_valid_r;
  assign out_take = out_valid_r && out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  assign two = (mode_r == gptw_pkg::MODE_TWO_LEVEL);
  assign w10 = two;
  assign pse = two ? pse_r : 1'b1;
  assign nxe = two ? 1'b0 : nxe_r;
  assign {f_ac, f_us, f_fe, f_wr} = req_flags_r;
  assign entry = two ? {32'b0, item.table_entry[31:0]} : item.table_entry;
  assign lvl_i = (levels_left_r == 3'd0) ? 2'd0 : 2'(levels_left_r - 3'd1);
  assign off_mask = ~({64{1'b1}} << page_shift_f(w10, lvl_i));
  assign new_base = entry[51:0] & gptw_pkg::ADDR_MASK[51:0];
  assign pdpte_addr = {1'b0, root_r[31:4], 4'b0000}
                    + {28'b0, item.virt_addr[31:30], 3'b000};

  // Evaluate one transaction against the walk state.
  always_comb begin
    walk_busy_nxt    = walk_busy_r;
    pdpte_stage_nxt  = pdpte_stage_r;
    levels_left_nxt  = levels_left_r;
    pending_addr_nxt = pending_addr_r;
    req_flags_nxt    = req_flags_r;
    table_base_nxt   = table_base_r;
    all_user_nxt     = all_user_r;
    all_writable_nxt = all_writable_r;
    res_vld          = 1'b0;
    res              = '0;
    prot             = 1'b0;
    fault            = 1'b0;
    finish           = 1'b0;
    au_new           = all_user_r;
    aw_new           = all_writable_r;

    if (item.func == gptw_pkg::FUNC_REQUEST) begin
      // New request: any walk in progress is dropped.
      res_vld          = 1'b1;
      pending_addr_nxt = item.virt_addr;
      req_flags_nxt    = {item.align_check_flag, item.user_access,
                          item.is_fetch, item.is_write};
      all_user_nxt     = 1'b1;
      all_writable_nxt = 1'b1;
      pdpte_stage_nxt  = 1'b0;
      case (mode_r)
        gptw_pkg::MODE_OFF: begin
          walk_busy_nxt = 1'b0;
          res.kind      = gptw_pkg::KIND_DONE;
          res.phys_addr = item.virt_addr;
        end
        gptw_pkg::MODE_PAE: begin
          walk_busy_nxt   = 1'b1;
          pdpte_stage_nxt = 1'b1;
          levels_left_nxt = 3'd0;
          res.kind        = gptw_pkg::KIND_READ;
          res.read_addr   = {19'b0, pdpte_addr};
          res.read_wide   = 1'b1;
        end
        default: begin
          walk_busy_nxt   = 1'b1;
          levels_left_nxt = two ? 3'd2 : 3'd4;
          table_base_nxt  = root_r & gptw_pkg::ADDR_MASK[51:0];
          res.kind        = gptw_pkg::KIND_READ;
          res.read_addr   = read_addr_f(root_r & gptw_pkg::ADDR_MASK[51:0],
                                        item.virt_addr, w10, two ? 2'd1 : 2'd3);
          res.read_wide   = !w10;
        end
      endcase
    end else if (walk_busy_r) begin
      res_vld = 1'b1;
      if (pdpte_stage_r) begin
        // PAE directory pointer entry.
        if (item.entry_error || !item.table_entry[gptw_pkg::BIT_P]) begin
          fault = 1'b1;
        end else begin
          pdpte_stage_nxt = 1'b0;
          levels_left_nxt = 3'd2;
          table_base_nxt  = item.table_entry[51:0] & gptw_pkg::ADDR_MASK[51:0];
          res.kind        = gptw_pkg::KIND_READ;
          res.read_addr   = read_addr_f(item.table_entry[51:0]
                                        & gptw_pkg::ADDR_MASK[51:0],
                                        pending_addr_r, w10, 2'd1);
          res.read_wide   = !w10;
        end
      end else begin
        // Regular level: presence, write, no-execute and user checks.
        aw_new = all_writable_r && entry[gptw_pkg::BIT_RW];
        au_new = all_user_r && entry[gptw_pkg::BIT_US];
        all_writable_nxt = aw_new;
        all_user_nxt     = au_new;
        if (item.entry_error || !entry[gptw_pkg::BIT_P]) begin
          fault = 1'b1;
        end else if (!entry[gptw_pkg::BIT_RW] && f_wr && (f_us || wp_r)) begin
          fault = 1'b1;
          prot  = 1'b1;
        end else if (f_fe && nxe && entry[gptw_pkg::BIT_NX]) begin
          fault = 1'b1;
          prot  = 1'b1;
        end else if (!entry[gptw_pkg::BIT_US] && f_us) begin
          fault = 1'b1;
          prot  = 1'b1;
        end else if (lvl_i == 2'd0 || (pse && entry[gptw_pkg::BIT_PS])) begin
          finish = 1'b1;
        end else begin
          levels_left_nxt = {1'b0, lvl_i};
          table_base_nxt  = new_base;
          res.kind        = gptw_pkg::KIND_READ;
          res.read_addr   = read_addr_f(new_base, pending_addr_r, w10,
                                        2'(lvl_i - 2'd1));
          res.read_wide   = !w10;
        end

        // End of walk: supervisor access and execution prevention.
        if (finish) begin
          if (smap_r && !f_us && au_new && !f_fe &&
              ((!f_wr && !f_ac) || (f_wr && (!f_ac || (wp_r && !aw_new))))) begin
            fault = 1'b1;
            prot  = 1'b1;
          end else if (smep_r && !f_us && au_new && f_fe) begin
            fault = 1'b1;
            prot  = 1'b1;
          end else begin
            walk_busy_nxt = 1'b0;
            res.kind      = gptw_pkg::KIND_DONE;
            res.phys_addr = (entry & gptw_pkg::PHYS_MASK & ~off_mask)
                          | (pending_addr_r & off_mask);
          end
        end
      end

      if (fault) begin
        walk_busy_nxt   = 1'b0;
        pdpte_stage_nxt = 1'b0;
        res             = '0;
        res.kind        = gptw_pkg::KIND_DONE;
        res.status      = 1'b1;
        res.fault_code  = {f_fe, 1'b0, f_us, f_wr, prot};
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gptw_pkg::MODE_OFF;
      root_r <= '0;
      wp_r   <= 1'b0;
      nxe_r  <= 1'b0;
      pse_r  <= 1'b0;
      smap_r <= 1'b0;
      smep_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        gptw_pkg::CFG_PAGING_MODE:   mode_r <= cfg_data[1:0];
        gptw_pkg::CFG_ROOT_POINTER:  root_r <= cfg_data;
        gptw_pkg::CFG_WRITE_PROTECT: wp_r   <= cfg_data[0];
        gptw_pkg::CFG_NO_EXEC:       nxe_r  <= cfg_data[0];
        gptw_pkg::CFG_LARGE_PAGE:    pse_r  <= cfg_data[0];
        gptw_pkg::CFG_SMAP:          smap_r <= cfg_data[0];
        gptw_pkg::CFG_SMEP:          smep_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Walk control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_busy_r   <= 1'b0;
      pdpte_stage_r <= 1'b0;
      levels_left_r <= 3'd0;
    end else if (in_take) begin
      walk_busy_r   <= walk_busy_nxt;
      pdpte_stage_r <= pdpte_stage_nxt;
      levels_left_r <= levels_left_nxt;
    end
  end

  // Walk context; always written by a request before it is read.
  always_ff @(posedge clk) begin
    if (in_take) begin
      pending_addr_r <= pending_addr_nxt;
      req_flags_r    <= req_flags_nxt;
      table_base_r   <= table_base_nxt;
      all_user_r     <= all_user_nxt;
      all_writable_r <= all_writable_nxt;
    end
  end

  // Output register with skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take && res_vld) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_take && res_vld) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A waiting skid entry always sits behind a valid output register.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  // The directory pointer stage only exists inside an active walk.
  assert property (@(posedge clk) disable iff (!rst_n) pdpte_stage_r |-> walk_busy_r)
    else $error("PDPTE stage set while walker is idle");

  // No walk ever has more than four levels outstanding.
  assert property (@(posedge clk) disable iff (!rst_n) levels_left_r <= 3'd4)
    else $error("level count out of range");

  // A reply taken while idle produces no transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_take && item.func == gptw_pkg::FUNC_REPLY && !walk_busy_r &&
                    !out_valid_r) |=> !out_valid_r)
    else $error("result produced for a reply while idle");
`endif

endmodule

`default_nettype wire

[tb/gptw_walk_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Guest page table walker checker
// Watches the walker's input, result and register write ports, keeps its own
// copy of the walk state and registers, predicts the result of every
// accepted transaction and compares each accepted result field by field
// against the oldest prediction. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------

module gptw_walk_checker
  import gptw_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  gptw_in_if         in_mon,
  gptw_out_if        out_mon,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [51:0] cfg_data,
  output int         fail_count,
  output int         expected_left
);

  // PAE pointer table lookup shapes, page offset width and report limit.
  localparam logic [63:0] PDPT_ALIGN_MASK = 64'h0000_0000_FFFF_FFF0;
  localparam int          PDPT_INDEX_SHIFT = 30;
  localparam int          PAGE_SHIFT = 12;
  localparam int          MAX_REPORTS = 10;

  // Register copies.
  logic [1:0]  mode_q;
  logic [51:0] root_q;
  logic        wp_q, nxe_q, pse_q, smap_q, smep_q;

  // Walk state copies.
  logic        walking, pdpte_pending, every_user, every_writable;
  logic [2:0]  levels_q;
  logic [63:0] walk_va;
  logic        req_write, req_fetch, req_user, req_ac;
  logic [51:0] next_table;

  out_item_t   pending_walk_results[$];
  out_item_t   want, got, predicted;
  logic        bad;
  int          failures = 0;
  int          pending_count = 0;

  assign fail_count = failures;
  assign expected_left = pending_count;

  function automatic int unsigned level_bits();
    return (mode_q == MODE_TWO_LEVEL) ? 10 : 9;
  endfunction

  // Read of the entry that the current level selects from next_table.
  function automatic out_item_t table_read();
    int unsigned w, shift;
    logic [1:0]  lvl_idx;
    logic [63:0] idx, addr;
    out_item_t   r;
    w = level_bits();
    lvl_idx = levels_q[1:0] - 2'd1;
    shift = lvl_idx * w + PAGE_SHIFT;
    idx = (walk_va >> shift) & ((64'd1 << w) - 64'd1);
    addr = {12'd0, next_table} + (idx << ((w == 10) ? 2 : 3));
    r = '0;
    r.kind = KIND_READ;
    r.read_addr = addr[51:0];
    r.read_wide = (w != 10);
    return r;
  endfunction

  // Page fault; the error code echoes the access type of the request.
  function automatic out_item_t walk_fault(logic prot);
    out_item_t r;
    walking = 1'b0;
    pdpte_pending = 1'b0;
    r = '0;
    r.kind = KIND_DONE;
    r.status = 1'b1;
    r.fault_code = {req_fetch, 1'b0, req_user, req_write, prot};
    return r;
  endfunction

  // End of a walk: supervisor access checks, then the translated address.
  function automatic out_item_t walk_done(logic [63:0] entry, int unsigned shift);
    logic [63:0] off, frame;
    out_item_t   r;
    off = (64'd1 << shift) - 64'd1;
    frame = entry & PHYS_MASK & ~off;
    if (smap_q && !req_user && every_user && !req_fetch) begin
      if (!req_write && !req_ac) return walk_fault(1'b1);
      if (req_write && (!req_ac || (wp_q && !every_writable))) return walk_fault(1'b1);
    end
    if (smep_q && !req_user && every_user && req_fetch) return walk_fault(1'b1);
    walking = 1'b0;
    r = '0;
    r.kind = KIND_DONE;
    r.phys_addr = frame | (walk_va & off);
    return r;
  endfunction

  // One table entry returned from memory during a walk.
  function automatic out_item_t entry_reply(logic [63:0] entry, logic err);
    logic        two, big, nx_on;
    logic [63:0] e, masked;
    logic [1:0]  lvl_idx;
    int unsigned shift;
    two = (mode_q == MODE_TWO_LEVEL);
    big = two ? pse_q : 1'b1;
    nx_on = two ? 1'b0 : nxe_q;
    e = entry;
    if (pdpte_pending) begin
      if (err || !e[BIT_P]) return walk_fault(1'b0);
      pdpte_pending = 1'b0;
      levels_q = 3'd2;
      masked = e & ADDR_MASK;
      next_table = masked[51:0];
      return table_read();
    end
    if (two) e = {32'd0, e[31:0]};
    if (err || !e[BIT_P]) return walk_fault(1'b0);
    if (!e[BIT_RW]) begin
      if (req_write && (req_user || wp_q)) return walk_fault(1'b1);
      every_writable = 1'b0;
    end
    if (req_fetch && nx_on && e[BIT_NX]) return walk_fault(1'b1);
    if (!e[BIT_US]) begin
      every_user = 1'b0;
      if (req_user) return walk_fault(1'b1);
    end
    lvl_idx = (levels_q == 3'd0) ? 2'd0 : (levels_q[1:0] - 2'd1);
    shift = lvl_idx * level_bits() + PAGE_SHIFT;
    if (lvl_idx == 2'd0 || (big && e[BIT_PS])) return walk_done(e, shift);
    levels_q = {1'b0, lvl_idx};
    masked = e & ADDR_MASK;
    next_table = masked[51:0];
    return table_read();
  endfunction

  // Predicts the result of one accepted transaction; returns 0 when none.
  function automatic logic walk_step(in_item_t it, output out_item_t r);
    logic [63:0] addr, masked;
    r = '0;
    if (it.func == FUNC_REPLY) begin
      if (!walking) return 1'b0;
      r = entry_reply(it.table_entry, it.entry_error);
      return 1'b1;
    end
    walk_va = it.virt_addr;
    req_write = it.is_write;
    req_fetch = it.is_fetch;
    req_user = it.user_access;
    req_ac = it.align_check_flag;
    every_user = 1'b1;
    every_writable = 1'b1;
    pdpte_pending = 1'b0;
    if (mode_q == MODE_OFF) begin
      walking = 1'b0;
      r.kind = KIND_DONE;
      r.phys_addr = walk_va;
      return 1'b1;
    end
    walking = 1'b1;
    if (mode_q == MODE_PAE) begin
      pdpte_pending = 1'b1;
      levels_q = 3'd0;
      addr = ({12'd0, root_q} & PDPT_ALIGN_MASK)
             + (((walk_va >> PDPT_INDEX_SHIFT) & 64'd3) << 3);
      r.kind = KIND_READ;
      r.read_addr = addr[51:0];
      r.read_wide = 1'b1;
      return 1'b1;
    end
    levels_q = (mode_q == MODE_TWO_LEVEL) ? 3'd2 : 3'd4;
    masked = {12'd0, root_q} & ADDR_MASK;
    next_table = masked[51:0];
    r = table_read();
    return 1'b1;
  endfunction

  // Results are retired before new transactions are predicted, so a result
  // never matches a prediction made at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = MODE_OFF;
      root_q = '0;
      {wp_q, nxe_q, pse_q, smap_q, smep_q} = '0;
      walking = 1'b0;
      pdpte_pending = 1'b0;
      levels_q = '0;
      walk_va = '0;
      {req_write, req_fetch, req_user, req_ac} = '0;
      next_table = '0;
      every_user = 1'b1;
      every_writable = 1'b1;
      pending_walk_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (pending_walk_results.size() == 0) begin
          if (failures < MAX_REPORTS)
            $display("%0t: walk result with nothing outstanding: kind=%0d ra=%h pa=%h",
                     $time, got.kind, got.read_addr, got.phys_addr);
          failures++;
        end else begin
          want = pending_walk_results.pop_front();
          bad = (got.kind !== want.kind) || (got.read_addr !== want.read_addr)
                || (got.read_wide !== want.read_wide) || (got.phys_addr !== want.phys_addr)
                || (got.status !== want.status) || (got.fault_code !== want.fault_code);
          if (bad) begin
            if (failures < MAX_REPORTS)
              $display({"%0t: walk result mismatch: expected kind=%0d ra=%h wide=%0d ",
                        "pa=%h st=%0d fc=%h, got kind=%0d ra=%h wide=%0d pa=%h st=%0d fc=%h"},
                       $time, want.kind, want.read_addr, want.read_wide, want.phys_addr,
                       want.status, want.fault_code, got.kind, got.read_addr,
                       got.read_wide, got.phys_addr, got.status, got.fault_code);
            failures++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (walk_step(in_mon.data, predicted)) pending_walk_results.push_back(predicted);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAGING_MODE: mode_q = cfg_data[1:0];
          CFG_ROOT_POINTER: root_q = cfg_data;
          CFG_WRITE_PROTECT: wp_q = cfg_data[0];
          CFG_NO_EXEC: nxe_q = cfg_data[0];
          CFG_LARGE_PAGE: pse_q = cfg_data[0];
          CFG_SMAP: smap_q = cfg_data[0];
          CFG_SMEP: smep_q = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending_count = pending_walk_results.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Guest page table walker testbench
// Acts as the guest and as page table memory: sends translation requests and
// entry replies, walks through all paging modes and register settings, and
// stalls the result side at random. A checker beside the walker predicts
// and compares every result; this module reports the verdict.
// ----------------------------------------------------------------------------

module tb;
  import gptw_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int RUN_LIMIT = 200000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 135;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [51:0] cfg_data;
  logic [1:0]  cur_mode = MODE_OFF;

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int items_sent = 0;
  int stall_mark = 32'h7FFF_FFFF;
  bit long_stall_done = 1'b0;
  int fail_count;
  int expected_left;

  gptw_in_if  walk_in ();
  gptw_out_if walk_out ();

  guest_page_table_walker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (walk_in),
    .out_chan  (walk_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gptw_walk_checker walk_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (walk_in),
    .out_mon       (walk_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("** guest_page_table_walker_core: FAILED **");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off that lets the
  // walker fill up while the sender keeps offering transactions.
  initial begin
    walk_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_stall_done && items_sent >= stall_mark) begin
        long_stall_done = 1'b1;
        walk_out.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end
      walk_out.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] paging_entry(logic [63:0] raw, logic p, logic rw,
                                               logic us, logic ps, logic nx);
    logic [63:0] e;
    e = raw;
    e[BIT_P] = p;
    e[BIT_RW] = rw;
    e[BIT_US] = us;
    e[BIT_PS] = ps;
    e[BIT_NX] = nx;
    return e;
  endfunction

  // Fields a transaction does not use are filled with noise.
  function automatic in_item_t request_item(logic [63:0] va, logic wr, logic fe,
                                            logic us, logic ac);
    in_item_t it;
    it.func = FUNC_REQUEST;
    it.virt_addr = va;
    it.is_write = wr;
    it.is_fetch = fe;
    it.user_access = us;
    it.align_check_flag = ac;
    it.table_entry = rand64();
    it.entry_error = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic in_item_t reply_item(logic [63:0] entry, logic err);
    in_item_t it;
    it.func = FUNC_REPLY;
    it.virt_addr = rand64();
    {it.is_write, it.is_fetch, it.user_access, it.align_check_flag} =
        4'($urandom_range(15));
    it.table_entry = entry;
    it.entry_error = err;
    return it;
  endfunction

  // Offers one transaction, with random gaps, and returns at its acceptance.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      walk_in.valid <= 1'b0;
      @(posedge clk);
    end
    walk_in.valid <= 1'b1;
    walk_in.data <= it;
    @(posedge clk);
    while (!walk_in.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [51:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_cfg(logic [1:0] mode, logic [51:0] root, logic wp, logic nxe,
                           logic pse, logic smap, logic smep);
    write_reg(CFG_PAGING_MODE, {50'd0, mode});
    write_reg(CFG_ROOT_POINTER, root);
    write_reg(CFG_WRITE_PROTECT, {51'd0, wp});
    write_reg(CFG_NO_EXEC, {51'd0, nxe});
    write_reg(CFG_LARGE_PAGE, {51'd0, pse});
    write_reg(CFG_SMAP, {51'd0, smap});
    write_reg(CFG_SMEP, {51'd0, smep});
    cfg_we <= 1'b0;
    cur_mode = mode;
  endtask

  // Waits until every predicted result has been taken, then lets any
  // ignored reply work its way through.
  task automatic settle();
    walk_in.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One request followed by the replies its walk needs; sometimes cut short
  // (the next request drops the walk) or followed by a stray reply.
  task automatic random_walk();
    int          depth;
    int          pick;
    logic [63:0] va;
    case (cur_mode)
      MODE_TWO_LEVEL: depth = 2;
      MODE_PAE: depth = 3;
      MODE_FOUR_LEVEL: depth = 4;
      default: depth = 0;
    endcase
    pick = $urandom_range(99);
    va = (pick < 5) ? '1 : (pick < 10) ? '0 : rand64();
    send_item(request_item(va, $urandom_range(99) < 40, $urandom_range(99) < 30,
                           1'($urandom_range(1)), 1'($urandom_range(1))));
    pick = $urandom_range(99);
    if (pick < 10 && depth > 0) depth = $urandom_range(depth - 1);
    else if (pick < 15) depth++;
    repeat (depth) begin
      send_item(reply_item(paging_entry(rand64(), $urandom_range(99) < 92,
                                        $urandom_range(99) < 80, $urandom_range(99) < 80,
                                        $urandom_range(99) < 12, $urandom_range(99) < 25),
                           $urandom_range(99) < 4));
    end
  endtask

  initial begin
    int          start_count;
    logic [63:0] raw;
    logic [1:0]  mode;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PAGING_MODE;
    cfg_data <= '0;
    walk_in.valid <= 1'b0;
    walk_in.data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 29;
    recv_gap_pct = 70;

    // Paging off: the address passes through; a reply while idle is dropped.
    apply_cfg(MODE_OFF, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(request_item('1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(reply_item('1, 1'b0));
    settle();

    // Two-level: a 4 MB page with the upper entry half set, a missing entry,
    // and an entry that is not backed by memory.
    apply_cfg(MODE_TWO_LEVEL, '1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(request_item('1, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(reply_item('1, 1'b0));
    send_item(request_item('0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(reply_item(paging_entry(rand64(), 1'b0, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0));
    send_item(request_item(rand64(), 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(reply_item('1, 1'b1));
    settle();

    // PAE: a large page stop that SMAP rejects, a missing pointer entry,
    // a request that drops a walk, and registers changed mid-walk.
    apply_cfg(MODE_PAE, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(request_item(64'h0000_0000_C000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0));
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b1, 1'b1, 1'b1, 1'b0), 1'b0));
    send_item(request_item(rand64(), 1'b0, 1'b1, 1'b0, 1'b1));
    send_item(reply_item('0, 1'b0));
    send_item(request_item(rand64(), 1'b1, 1'b0, 1'b0, 1'b1));
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0));
    send_item(request_item(rand64(), 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0));
    settle();
    apply_cfg(MODE_PAE, '1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0));
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b1, 1'b1, 1'b0, 1'b0), 1'b0));
    settle();

    // Four-level: a 512 GB page fetched under SMAP, a no-execute fault and
    // a user write to a read-only page.
    apply_cfg(MODE_FOUR_LEVEL, '0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_item(request_item('1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b1, 1'b1, 1'b1, 1'b0), 1'b0));
    send_item(request_item(rand64(), 1'b0, 1'b1, 1'b1, 1'b0));
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b1, 1'b1, 1'b0, 1'b1), 1'b0));
    send_item(request_item(rand64(), 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(reply_item(paging_entry(rand64(), 1'b1, 1'b0, 1'b1, 1'b0, 1'b0), 1'b0));
    settle();

    // Random walks over a series of register settings and idle patterns.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode = (ph % 5 == 4) ? MODE_OFF : 2'(1 + ph % 3);
      raw = rand64();
      if (ph == 0) apply_cfg(mode, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      else if (ph == 1) apply_cfg(mode, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      else apply_cfg(mode, raw[51:0], 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
      if (ph < 4) begin
        send_gap_pct = 29;
        recv_gap_pct = 70;
      end else if (ph < 8) begin
        send_gap_pct = 70;
        recv_gap_pct = 29;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      start_count = items_sent;
      if (ph == 9) stall_mark = items_sent + 40;
      while (items_sent - start_count < PHASE_ITEMS) random_walk();
      settle();
    end

    if (fail_count == 0 && expected_left == 0) begin
      $display("** guest_page_table_walker_core: PASSED **");
    end else begin
      $display("** guest_page_table_walker_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
hdl/gptw_pkg.sv
hdl/gptw_if.sv
hdl/guest_page_table_walker_core.sv
tb/gptw_walk_checker.sv
tb/tb.sv
